// ----- rtl/cbe_pkg.sv -----
package cbe_pkg;

    // Field and register widths
    localparam int IN_W      = 18;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 2;

    // Output fixed point: Q1.FRAC_BITS
    localparam int FRAC_BITS = 16;
    localparam int OUT_W     = FRAC_BITS + 1;
    localparam logic [OUT_W-1:0] OUT_ONE = OUT_W'(1) << FRAC_BITS;

    // Curve parameter: unsigned Q1.24, range 0..1.0 inclusive
    localparam int TBITS  = 24;
    localparam int T_W    = TBITS + 1;
    localparam logic [T_W-1:0] T_ONE = T_W'(1) << TBITS;
    localparam int CSHIFT = TBITS - FRAC_BITS;
    localparam logic [T_W-1:0] T_ROUND = T_W'(1) << (CSHIFT - 1);

    // Control points are scaled by 1/127
    localparam int CTRL_SCALE = 127;

    // Datapath widths: weights carry a factor of three, the sum stays below 2^31
    localparam int W_W     = T_W + 2;
    localparam int ACC_W   = 32;
    localparam int M_W     = ACC_W - CSHIFT;
    localparam int MUL_A_W = W_W;
    localparam int MUL_B_W = T_W;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // Rounding offset of the final scale, half of 127 << CSHIFT
    localparam logic [ACC_W-1:0] HALF_D = ACC_W'((CTRL_SCALE << CSHIFT) / 2);

    // Reciprocal of 127 for the constant division
    localparam int RECIP_SHIFT = 30;
    localparam logic [MUL_B_W-1:0] RECIP =
        MUL_B_W'((64'd1 << RECIP_SHIFT) / 64'd127);

    // Bisection length
    localparam int ITERATIONS = 32;
    localparam int ITER_W     = (ITERATIONS > 1) ? $clog2(ITERATIONS) : 1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CTRL1_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CTRL1_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CTRL2_X = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CTRL2_Y = 2'd3;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MID,
        ST_T2,
        ST_U2,
        ST_T3,
        ST_A,
        ST_B,
        ST_P1,
        ST_P2,
        ST_SUM,
        ST_RECIP,
        ST_FIX,
        ST_DECIDE,
        ST_OUT
    } cbe_state_t;

    // Datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MID,
        OP_T2,
        OP_U2,
        OP_T3,
        OP_A,
        OP_B,
        OP_P1,
        OP_P2,
        OP_SUM,
        OP_RECIP,
        OP_FIX,
        OP_DECIDE,
        OP_OUT
    } cbe_op_t;

    typedef struct packed {
        cbe_op_t op;
        logic    use_y;
    } cbe_cmd_t;

    typedef struct packed {
        logic close;
        logic out_free;
    } cbe_status_t;

endpackage

// ----- rtl/cbe_datapath.sv -----
module cbe_datapath
    import cbe_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic [IN_W-1:0]      s_time_in,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [OUT_W-1:0]     m_eased_value,
    output logic [OUT_W-1:0]     m_curve_param,
    input  cbe_cmd_t             cmd,
    output cbe_status_t          status
);

    logic [CFG_W-1:0]   ctrl1_x_reg, ctrl1_y_reg, ctrl2_x_reg, ctrl2_y_reg;
    logic [OUT_W-1:0]   time_reg;
    logic [T_W-1:0]     start_reg, stop_reg, t_reg;
    logic [T_W-1:0]     t2_reg, u2_reg, t3_reg;
    logic [W_W-1:0]     w1_reg, w2_reg;
    logic [ACC_W-1:0]   acc_reg;
    logic [OUT_W-1:0]   q_est_reg, x_reg;
    logic [OUT_W-1:0]   eased_reg, param_reg;
    logic               m_valid_reg;

    logic [T_W-1:0]     u;
    logic [CFG_W-1:0]   c1, c2;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [PROD_W-1:0]  prod;
    logic [T_W-1:0]     prod_hi;
    logic [W_W-1:0]     triple;
    logic [M_W-1:0]     m_val;
    logic [T_W-1:0]     rem;
    logic [OUT_W-1:0]   diff;
    logic [OUT_W-1:0]   time_clamped;
    logic [T_W:0]       mid_sum;
    logic [T_W-1:0]     param_sum;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl1_x_reg <= '0;
            ctrl1_y_reg <= '0;
            ctrl2_x_reg <= '0;
            ctrl2_y_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_CTRL1_X: ctrl1_x_reg <= cfg_wdata;
                REG_CTRL1_Y: ctrl1_y_reg <= cfg_wdata;
                REG_CTRL2_X: ctrl2_x_reg <= cfg_wdata;
                REG_CTRL2_Y: ctrl2_y_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // The x phase uses the x coordinates, the final pass the y coordinates.
    assign c1 = cmd.use_y ? ctrl1_y_reg : ctrl1_x_reg;
    assign c2 = cmd.use_y ? ctrl2_y_reg : ctrl2_x_reg;
    assign u  = T_ONE - t_reg;

    // Shared multiplier operand selection
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            OP_T2: begin
                mul_a = MUL_A_W'(t_reg);
                mul_b = t_reg;
            end
            OP_U2: begin
                mul_a = MUL_A_W'(u);
                mul_b = u;
            end
            OP_T3: begin
                mul_a = MUL_A_W'(t2_reg);
                mul_b = t_reg;
            end
            OP_A: begin
                mul_a = MUL_A_W'(u2_reg);
                mul_b = t_reg;
            end
            OP_B: begin
                mul_a = MUL_A_W'(u);
                mul_b = t2_reg;
            end
            OP_P1: begin
                mul_a = w1_reg;
                mul_b = MUL_B_W'(c1);
            end
            OP_P2: begin
                mul_a = w2_reg;
                mul_b = MUL_B_W'(c2);
            end
            OP_RECIP: begin
                mul_a = MUL_A_W'(m_val);
                mul_b = RECIP;
            end
            default: ;
        endcase
    end

    assign prod    = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign prod_hi = prod[TBITS +: T_W];
    assign triple  = W_W'(prod_hi) + (W_W'(prod_hi) << 1);

    // Sum scaled down by the power-of-two part of the divisor
    assign m_val = acc_reg[CSHIFT +: M_W];

    // Remainder after the reciprocal estimate, used to correct by one
    assign rem = T_W'(m_val) - (T_W'(q_est_reg) << 7) + T_W'(q_est_reg);

    // Distance between the target time and the curve x
    assign diff = (time_reg > x_reg) ? (time_reg - x_reg) : (x_reg - time_reg);

    // Input clamp to 0..1.0
    always_comb begin
        if (s_time_in[IN_W-1]) begin
            time_clamped = '0;
        end else if (s_time_in[OUT_W-1:0] > OUT_ONE || s_time_in[IN_W-2] &&
                     s_time_in[OUT_W-1:0] != '0) begin
            time_clamped = OUT_ONE;
        end else begin
            time_clamped = s_time_in[OUT_W-1:0];
        end
    end

    assign mid_sum   = (T_W + 1)'(start_reg) + (T_W + 1)'(stop_reg);
    assign param_sum = t_reg + T_ROUND;

    // Datapath registers, one operation per cycle
    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            OP_LOAD: begin
                time_reg  <= time_clamped;
                start_reg <= '0;
                stop_reg  <= T_ONE;
            end
            OP_MID:    t_reg     <= mid_sum[T_W:1];
            OP_T2:     t2_reg    <= prod_hi;
            OP_U2:     u2_reg    <= prod_hi;
            OP_T3:     t3_reg    <= prod_hi;
            OP_A:      w1_reg    <= triple;
            OP_B:      w2_reg    <= triple;
            OP_P1:     acc_reg   <= prod[ACC_W-1:0];
            OP_P2:     acc_reg   <= acc_reg + prod[ACC_W-1:0];
            OP_SUM: begin
                acc_reg <= acc_reg + (ACC_W'(t3_reg) << 7) - ACC_W'(t3_reg) + HALF_D;
            end
            OP_RECIP:  q_est_reg <= prod[RECIP_SHIFT +: OUT_W];
            OP_FIX: begin
                if (rem >= T_W'(CTRL_SCALE)) begin
                    x_reg <= q_est_reg + OUT_W'(1);
                end else begin
                    x_reg <= q_est_reg;
                end
            end
            OP_DECIDE: begin
                if (diff > OUT_W'(1)) begin
                    if (time_reg < x_reg) begin
                        stop_reg <= t_reg;
                    end else begin
                        start_reg <= t_reg;
                    end
                end
            end
            OP_OUT: begin
                eased_reg <= x_reg;
                param_reg <= param_sum[CSHIFT +: OUT_W];
            end
            default: ;
        endcase
    end

    // Output word valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.op == OP_OUT) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_eased_value   = eased_reg;
    assign m_curve_param   = param_reg;
    assign status.close    = (diff <= OUT_W'(1));
    assign status.out_free = !m_valid_reg || m_ready;

`ifndef SYNTH
    a_time_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_LOAD) |=> (time_reg <= OUT_ONE))
        else $error("clamped time exceeds one");

    a_interval_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_DECIDE) |=> (start_reg <= stop_reg && stop_reg <= T_ONE))
        else $error("bisection interval out of order");

    a_x_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_FIX) |=> (x_reg <= OUT_ONE))
        else $error("curve value exceeds one");
`endif

endmodule

// ----- rtl/cbe_ctrl.sv -----
module cbe_ctrl
    import cbe_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    output cbe_cmd_t    cmd,
    input  cbe_status_t status
);

    cbe_state_t        state_reg, state_next;
    logic [ITER_W-1:0] iter_reg, iter_next;
    logic              phase_y_reg, phase_y_next;

    // State, iteration count and phase registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            iter_reg    <= '0;
            phase_y_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            iter_reg    <= iter_next;
            phase_y_reg <= phase_y_next;
        end
    end

    // Sequencing of one curve evaluation per bisection step, then the y pass
    always_comb begin
        state_next   = state_reg;
        iter_next    = iter_reg;
        phase_y_next = phase_y_reg;
        s_ready      = 1'b0;
        cmd.op       = OP_NONE;
        cmd.use_y    = phase_y_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op       = OP_LOAD;
                    iter_next    = '0;
                    phase_y_next = 1'b0;
                    state_next   = ST_MID;
                end
            end
            ST_MID: begin
                cmd.op     = OP_MID;
                state_next = ST_T2;
            end
            ST_T2: begin
                cmd.op     = OP_T2;
                state_next = ST_U2;
            end
            ST_U2: begin
                cmd.op     = OP_U2;
                state_next = ST_T3;
            end
            ST_T3: begin
                cmd.op     = OP_T3;
                state_next = ST_A;
            end
            ST_A: begin
                cmd.op     = OP_A;
                state_next = ST_B;
            end
            ST_B: begin
                cmd.op     = OP_B;
                state_next = ST_P1;
            end
            ST_P1: begin
                cmd.op     = OP_P1;
                state_next = ST_P2;
            end
            ST_P2: begin
                cmd.op     = OP_P2;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                cmd.op     = OP_SUM;
                state_next = ST_RECIP;
            end
            ST_RECIP: begin
                cmd.op     = OP_RECIP;
                state_next = ST_FIX;
            end
            ST_FIX: begin
                cmd.op     = OP_FIX;
                state_next = phase_y_reg ? ST_OUT : ST_DECIDE;
            end
            ST_DECIDE: begin
                // A close match keeps t; otherwise halve or finish on the midpoint.
                cmd.op = OP_DECIDE;
                if (status.close) begin
                    phase_y_next = 1'b1;
                    state_next   = ST_T2;
                end else if (iter_reg == ITER_W'(ITERATIONS - 1)) begin
                    phase_y_next = 1'b1;
                    state_next   = ST_MID;
                end else begin
                    iter_next  = iter_reg + ITER_W'(1);
                    state_next = ST_MID;
                end
            end
            ST_OUT: begin
                if (status.out_free) begin
                    cmd.op     = OP_OUT;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTH
    a_decide_in_x_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DECIDE) |-> !phase_y_reg)
        else $error("bisection decision during the y pass");

    a_accept_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (iter_reg == '0 && !phase_y_reg))
        else $error("new word did not restart the search");

    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_OUT) |-> status.out_free)
        else $error("result loaded over a pending word");
`endif

endmodule

// ----- rtl/cubic_bezier_easing_eval.sv -----
// The bisection search stops after k steps (1 <= k <= 32): early on a close
// match of the curve x, else when all 32 have run; then the y pass follows.
// Throughput: one word at a time; the next word is taken the cycle after the
// result is loaded. Each curve evaluation runs on one shared multiplier.
// Reset: synchronous, active low; clears the controller, the output valid flag
// and the four control point registers.
module cubic_bezier_easing_eval
    import cbe_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [IN_W-1:0]      s_time_in,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [OUT_W-1:0]     m_eased_value,
    output logic [OUT_W-1:0]     m_curve_param
);

    cbe_cmd_t    cmd;
    cbe_status_t status;

    // Sequencer
    cbe_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .status  (status)
    );

    // Arithmetic, configuration and output register
    cbe_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_time_in     (s_time_in),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_eased_value (m_eased_value),
        .m_curve_param (m_curve_param),
        .cmd           (cmd),
        .status        (status)
    );

endmodule
